// ===== rtl/mbrr_pkg.sv =====
// Package for the read-register responder: table sizes, protocol constants,
// operation/result codes, sequencer states and the table port structs.
// No dependencies; imported by mbrr_table and modbus_read_register_responder.
package mbrr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int TBL_AW      = 5;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int MAX_REGS    = 125;

  localparam logic [7:0] FC_HOLDING = 8'h03;
  localparam logic [7:0] FC_INPUT   = 8'h04;
  localparam logic [7:0] EXC_FLAG   = 8'h80;
  localparam logic [7:0] STATION_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_LOAD_HOLD  = 2'd1,
    OP_LOAD_INPUT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_EXC    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_VALUE = 2'd1,
    ERR_ADDR  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FIRST,
    ST_WORD
  } state_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [15:0]       data;
  } tbl_wr_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
  } tbl_rd_t;

endpackage

// ===== rtl/mbrr_table.sv =====
// One register table: a word memory with a registered read port and
// per-entry valid bits, so that entries never written read as zero.
// Depends on mbrr_pkg.
module mbrr_table (
  input  logic            clk,
  input  logic            rst,
  input  mbrr_pkg::tbl_wr_t wr,
  input  mbrr_pkg::tbl_rd_t rd,
  output logic [15:0]     rd_data
);
  import mbrr_pkg::*;

  logic [15:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Reset clears the valid bits only; the memory itself is never swept.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= valid[rd.addr] ? mem[rd.addr] : 16'd0;
    end
  end

endmodule

// ===== rtl/modbus_read_register_responder.sv =====
// Read-register responder for function 3 (holding) and function 4 (input).
// The header or exception is registered out of CHECK; data words follow one
// per cycle from WORD, after FIRST has issued the first table read. busy
// spans CHECK, FIRST and one WORD state per word on a read with data, CHECK
// alone on an exception; load, foreign or ignored items never raise busy.
// Reset: station_address returns to 1, both tables read as zero, no strobe.
module modbus_read_register_responder (
  input  logic        clk,
  input  logic        rst,
  // Configuration: station_address.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Request side.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  unit_id,
  input  logic [7:0]  func_code,
  input  logic [15:0] start_addr,
  input  logic [15:0] reg_count,
  input  logic [4:0]  table_index,
  input  logic [15:0] table_value,
  // Result side.
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [7:0]  reply_unit,
  output logic [7:0]  reply_function,
  output logic [6:0]  byte_count,
  output logic [1:0]  error_kind,
  output logic [15:0] data_word,
  output logic        last
);
  import mbrr_pkg::*;

  // Sequencer and request registers.
  state_t            state;
  state_t            state_next;
  logic [7:0]        station_address;
  logic [7:0]        req_fc;
  logic [15:0]       req_addr;
  logic [15:0]       req_count;
  logic [CNT_W-1:0]  remaining;

  // The one shared adder: it forms start + count for the range check, then
  // steps the read address once per word.
  logic [16:0]       add_a;
  logic [16:0]       add_b;
  logic [16:0]       add_sum;

  logic              accept;
  logic              is_read;
  logic              count_bad;
  tbl_wr_t           hold_wr;
  tbl_wr_t           inp_wr;
  tbl_rd_t           rd;
  logic [15:0]       hold_rd_data;
  logic [15:0]       inp_rd_data;
  logic [15:0]       table_word;

  // Result staged for the output registers.
  logic              emit;
  kind_t             emit_kind;
  logic [7:0]        emit_fc;
  logic [6:0]        emit_bytes;
  err_t              emit_err;
  logic [15:0]       emit_word;
  logic              emit_last;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // A read transaction only starts the sequencer when it is addressed to this
  // station and asks for one of the two supported functions; anything else is
  // dropped silently.
  assign is_read = accept && (op == OP_READ) && (unit_id == station_address) &&
                   ((func_code == FC_HOLDING) || (func_code == FC_INPUT));

  assign count_bad = (req_count == 16'd0) || (req_count > 16'(MAX_REGS));
  assign add_sum   = add_a + add_b;

  // Load transactions write straight into the selected table.
  always_comb begin
    hold_wr.en   = accept && (op == OP_LOAD_HOLD);
    hold_wr.addr = table_index;
    hold_wr.data = table_value;
    inp_wr.en    = accept && (op == OP_LOAD_INPUT);
    inp_wr.addr  = table_index;
    inp_wr.data  = table_value;
  end

  mbrr_table u_hold_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (hold_wr),
    .rd      (rd),
    .rd_data (hold_rd_data)
  );

  mbrr_table u_inp_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (inp_wr),
    .rd      (rd),
    .rd_data (inp_rd_data)
  );

  assign table_word = (req_fc == FC_INPUT) ? inp_rd_data : hold_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= STATION_RESET;
    end else if (cfg_we) begin
      station_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, adder operands, table read and the result to emit.
  // CHECK resolves the request: exception, or header and then the word loop.
  // FIRST issues the first table read; each WORD cycle returns one word and
  // issues the read for the following address.
  always_comb begin
    state_next = state;
    add_a      = {1'b0, req_addr};
    add_b      = 17'd1;
    rd.en      = 1'b0;
    rd.addr    = req_addr[TBL_AW-1:0];
    emit       = 1'b0;
    emit_kind  = KIND_HEADER;
    emit_fc    = req_fc;
    emit_bytes = 7'd0;
    emit_err   = ERR_NONE;
    emit_word  = 16'd0;
    emit_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (is_read) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        add_b      = {1'b0, req_count};
        emit       = 1'b1;
        state_next = ST_IDLE;
        // The end address start + count - 1 lies past the table exactly when
        // start + count exceeds the table depth.
        priority if (count_bad) begin
          emit_kind = KIND_EXC;
          emit_fc   = req_fc | EXC_FLAG;
          emit_err  = ERR_VALUE;
          emit_last = 1'b1;
        end else if (add_sum > 17'(TABLE_DEPTH)) begin
          emit_kind = KIND_EXC;
          emit_fc   = req_fc | EXC_FLAG;
          emit_err  = ERR_ADDR;
          emit_last = 1'b1;
        end else begin
          emit_kind  = KIND_HEADER;
          emit_bytes = {req_count[CNT_W-1:0], 1'b0};
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        rd.en      = 1'b1;
        state_next = ST_WORD;
      end
      ST_WORD: begin
        rd.en     = 1'b1;
        emit      = 1'b1;
        emit_kind = KIND_DATA;
        emit_word = table_word;
        emit_last = (remaining == CNT_W'(1));
        if (emit_last) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Request registers; the address register steps through the shared adder.
  always_ff @(posedge clk) begin
    if (is_read) begin
      req_fc    <= func_code;
      req_addr  <= start_addr;
      req_count <= reg_count;
    end
    if (state == ST_CHECK) begin
      remaining <= req_count[CNT_W-1:0];
    end
    if (state == ST_FIRST) begin
      req_addr <= add_sum[15:0];
    end
    if (state == ST_WORD) begin
      req_addr  <= add_sum[15:0];
      remaining <= remaining - CNT_W'(1);
    end
  end

  // Result registers: each result is shown for one cycle under strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind           <= emit_kind;
      reply_unit     <= station_address;
      reply_function <= emit_fc;
      byte_count     <= emit_bytes;
      error_kind     <= emit_err;
      data_word      <= emit_word;
      last           <= emit_last;
    end
  end

`ifndef SYNTHESIS
  // A result only ever comes out of a cycle in which the sequencer was active.
  a_strobe_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result strobe without an active request");

  // The final result of a reply leaves the block ready for a new transaction.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("sequencer still busy after the final result");

  // An exception is a single result carrying the exception flag.
  a_exc_form: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == KIND_EXC)) |-> (last && reply_function[7]))
    else $error("malformed exception result");

  // A header is followed by a strobe-free gap and then by the first data word.
  a_header_then_data: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == KIND_HEADER)) |=> !strobe ##1 (strobe && (kind == KIND_DATA)))
    else $error("header not followed by data");

  // Data words of one reply come out on consecutive cycles.
  a_data_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && (kind == KIND_DATA) && !last) |=> (strobe && (kind == KIND_DATA)))
    else $error("gap inside a data word burst");
`endif

endmodule
